FILE: hw/rtl/pal_pkg.sv
// Shared types and codes for the positional array list.
// No dependencies; imported by every module of the block.
package pal_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_ERASE  = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_MODIFY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Fixed list depth; the position, index and count ports are sized for it.
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned POS_W    = 5;

  // Broadcast command to every cell; each bit already qualified by status.
  typedef struct packed {
    logic ins;
    logic era;
    logic mod;
  } pal_cmd_t;

endpackage

FILE: hw/rtl/pal_cell.sv
// One storage cell of the list chain: holds one entry and trades with neighbors.
// Depends on pal_pkg for the command struct.
module pal_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PW         = 5
) (
  input  logic                  clk,
  input  pal_pkg::pal_cmd_t     cmd,
  input  logic [PW-1:0]         pos,
  input  logic [PW-1:0]         cnt,
  input  logic [DATA_WIDTH-1:0] val,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  match
);
  import pal_pkg::*;

  localparam logic [PW-1:0] MY = PW'(IDX);

  logic [DATA_WIDTH-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (MY > pos) entry_next = left;
      else if (MY == pos) entry_next = val;
    end else if (cmd.era) begin
      if (MY >= pos) entry_next = right;
    end else if (cmd.mod) begin
      if (MY == pos) entry_next = val;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // Only live cells (below the count) take part in a search.
  assign match = (MY < cnt) && (entry == val);

endmodule

FILE: hw/rtl/pal_penc.sv
// Priority encoder: lowest set bit of a registered match vector.
// Depends on pal_pkg only by convention; no shared types used.
module pal_penc #(
  parameter int unsigned N  = 16,
  parameter int unsigned IW = 4
) (
  input  logic [N-1:0]  req,
  output logic [IW-1:0] idx,
  output logic          hit
);
  import pal_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) idx = IW'(i);
    end
  end

  assign hit = |req;

endmodule

FILE: hw/rtl/positional_array_list_core.sv
// Top level of the positional array list: cell chain, control and result register.
// Depends on pal_pkg, pal_cell and pal_penc.

// A bounded ordered list of CAPACITY signed entries supporting insert, erase,
// find and modify. In the accept cycle all cells shift or write in parallel
// and compare their entry against the value, latching a match bit; then, once
// the output register is free or draining, a priority encoder over those match
// bits picks the lowest hit and the result is loaded into the output register.
// The input therefore stays low from accept until that result is loaded, also
// while a finished result cannot enter a full output register. A result
// waiting at the output does not stop the next item from being accepted.
// Out-of-range positions report bad position and an insert into a full list
// reports full; neither changes the list. Entries above the count are never
// read, so the cells need no reset.
module positional_array_list_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     action,
  input  logic [pal_pkg::POS_W-1:0]      position,
  input  logic signed [31:0]             value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pal_pkg::STATUS_W-1:0]   status,
  output logic [pal_pkg::INDEX_W-1:0]    found_index,
  output logic [pal_pkg::COUNT_W-1:0]    count
);
  import pal_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  // Control state
  logic          busy;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;

  // Held from the accept cycle to the finish cycle
  logic                pend_find;
  logic [1:0]          pend_status;
  logic [CAPACITY-1:0] match_q;

  logic in_fire;
  logic finish;

  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic [DATA_WIDTH-1:0] val_x;
  logic [1:0]            new_status;
  pal_cmd_t              cmd;

  logic [DATA_WIDTH-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [IW-1:0]         enc_idx;
  logic                  enc_hit;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  // Retire the pending operation when the output register is free or draining.
  assign finish   = busy && (!out_valid || out_ready);

  assign pos_x = PW'(position);
  assign cnt_x = PW'(entry_count);
  assign val_x = DATA_WIDTH'(value);

  // Decode the operation and its status against the current count.
  always_comb begin
    new_status       = ST_OK;
    cmd              = '0;
    entry_count_next = entry_count;
    unique case (action)
      ACT_INSERT: begin
        if (pos_x > cnt_x) begin
          new_status = ST_BAD_POS;
        end else if (entry_count == CW'(CAPACITY)) begin
          new_status = ST_FULL;
        end else begin
          cmd.ins          = 1'b1;
          entry_count_next = entry_count + CW'(1);
        end
      end
      ACT_ERASE: begin
        if (pos_x >= cnt_x) begin
          new_status = ST_BAD_POS;
        end else begin
          cmd.era          = 1'b1;
          entry_count_next = entry_count - CW'(1);
        end
      end
      ACT_FIND: begin
        new_status = ST_NOT_FOUND;
      end
      ACT_MODIFY: begin
        if (pos_x >= cnt_x) new_status = ST_BAD_POS;
        else cmd.mod = 1'b1;
      end
      default: new_status = ST_OK;
    endcase
    // Hold every cell unless a transaction is actually taken.
    if (!in_fire) cmd = '0;
  end

  // Neighbor chain: cell 0's left is the value, the last cell's right is itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = val_x;
    end else begin : g_mid_l
      assign left_d = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = ent[i];
    end else begin : g_mid_r
      assign right_d = ent[i+1];
    end
    pal_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (pos_x),
      .cnt   (cnt_x),
      .val   (val_x),
      .left  (left_d),
      .right (right_d),
      .entry (ent[i]),
      .match (match[i])
    );
  end

  pal_penc #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_penc (
    .req (match_q),
    .idx (enc_idx),
    .hit (enc_hit)
  );

  // Control: busy flag and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_count <= '0;
    end else begin
      if (in_fire) begin
        busy        <= 1'b1;
        entry_count <= entry_count_next;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  // Capture match bits and status at accept; they need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      match_q     <= match;
      pend_find   <= (action == ACT_FIND);
      pend_status <= new_status;
    end
  end

  // Output register: load on finish, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      count <= COUNT_W'(entry_count);
      if (pend_find && enc_hit) begin
        status      <= ST_OK;
        found_index <= INDEX_W'(enc_idx);
      end else begin
        status      <= pend_status;
        found_index <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && cmd.ins |=> entry_count == $past(entry_count) + CW'(1))
    else $error("accepted insert did not grow the list");

  a_find_keeps: assert property (@(posedge clk) disable iff (rst)
    in_fire && (action == ACT_FIND) |=> entry_count == $past(entry_count))
    else $error("find changed the entry count");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> found_index == '0)
    else $error("nonzero index on a failed operation");
`endif

endmodule
